// ----- sv/clock_step_position_tracker_top_defines.svh -----
// assertion macros for the clock step position tracker
// used by clock_step_position_tracker_top, no other dependencies
`ifndef CLOCK_STEP_POSITION_TRACKER_TOP_DEFINES_SVH
`define CLOCK_STEP_POSITION_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CSPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSPT_ASSERT_RST(lbl, rstx, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rstx) prop) else $error(msg);
`else
`define CSPT_ASSERT(lbl, prop, msg)
`define CSPT_ASSERT_RST(lbl, rstx, prop, msg)
`endif
`endif

// ----- sv/cspt_pkg.sv -----
// shared types, constants and helpers of the clock step position tracker
// no dependencies
package cspt_pkg;

  // field and register widths
  localparam int KNOB_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int GATE_W     = 2;
  localparam int STEP_W     = 8;
  localparam int MEAS_W     = 8;
  localparam int CIM_W      = 7;
  localparam int TPB_W      = 4;
  localparam int PLEN_W     = 9;
  localparam int MODE_W     = 2;
  localparam int PH_W       = 3;
  localparam int NUM_LANES  = 5;
  localparam int LANE_W     = $clog2(NUM_LANES);

  // shared divider
  localparam int DIV_NUM_W  = 13;
  localparam int DIV_DEN_W  = 9;
  localparam int DIV_CNT_W  = 4;
  localparam logic [DIV_CNT_W-1:0] ITER_QUOT = DIV_CNT_W'(12);
  localparam logic [DIV_CNT_W-1:0] ITER_MOD  = DIV_CNT_W'(13);
  localparam logic [DIV_CNT_W-1:0] ITER_LANE = DIV_CNT_W'(8);

  // input kinds
  localparam logic KIND_CLOCK = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // clock gate report codes
  localparam logic [GATE_W-1:0] GATE_NONE  = 2'd0;
  localparam logic [GATE_W-1:0] GATE_SET   = 2'd1;
  localparam logic [GATE_W-1:0] GATE_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPB      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 3'd3;

  // subdivision modes
  localparam logic [MODE_W-1:0] MODE_X4 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X8 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_64 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_96 = 2'd3;

  localparam logic [CIM_W-1:0] CPM_64 = CIM_W'(16 * 4);
  localparam logic [CIM_W-1:0] CPM_96 = CIM_W'(24 * 4);

  localparam logic [TPB_W-1:0] TPB_RESET  = 4'd4;
  localparam logic [TPB_W-1:0] TPB_MAX    = 4'd8;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 9'd64;
  localparam logic [PH_W-1:0]  DIV_NONE   = 3'd0;

  // knob band thresholds, knob scaled by 256
  localparam logic [2*KNOB_W-1:0] KNOB_T1 = 16'((65536 * 1) / 5);
  localparam logic [2*KNOB_W-1:0] KNOB_T2 = 16'((65536 * 2) / 5);
  localparam logic [2*KNOB_W-1:0] KNOB_T3 = 16'((65536 * 3) / 5);
  localparam logic [2*KNOB_W-1:0] KNOB_T4 = 16'((65536 * 4) / 5);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;   // left aligned to the iteration count
    logic [DIV_DEN_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

  // divider 1..5 from the knob band
  function automatic logic [PH_W-1:0] pick_divider(input logic [KNOB_W-1:0] knob);
    logic [2*KNOB_W-1:0] v;
    logic [PH_W-1:0]     r;
    v = {knob, {KNOB_W{1'b0}}};
    r = '0;
    if (v > KNOB_T1) r = r + 3'd1;
    if (v > KNOB_T2) r = r + 3'd1;
    if (v > KNOB_T3) r = r + 3'd1;
    if (v > KNOB_T4) r = r + 3'd1;
    return PH_W'(NUM_LANES) - r;
  endfunction

  // remainder of a small phase by a divider of 1..5
  function automatic logic [PH_W-1:0] small_mod(input logic [PH_W-1:0] a,
                                                input logic [PH_W-1:0] d);
    logic [PH_W-1:0] r;
    r = a;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (r >= d) r = r - d;
    end
    return r;
  endfunction

endpackage

// ----- sv/cspt_evt_if.sv -----
// input channel of the clock step position tracker
// depends on cspt_pkg
interface cspt_evt_if;
  import cspt_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              clock_level;
  logic [KNOB_W-1:0] tempo_knob;

  modport source (output valid, kind, clock_level, tempo_knob, input ready);
  modport sink (input valid, kind, clock_level, tempo_knob, output ready);
endinterface

// ----- sv/cspt_pos_if.sv -----
// result channel of the clock step position tracker
// depends on cspt_pkg
interface cspt_pos_if;
  import cspt_pkg::*;
  logic              valid;
  logic              ready;
  logic              step_fired;
  logic [STEP_W-1:0] step_index;
  logic [MEAS_W-1:0] measure_count;
  logic [GATE_W-1:0] clock_gate;

  modport source (output valid, step_fired, step_index, measure_count, clock_gate,
                  input ready);
  modport sink (input valid, step_fired, step_index, measure_count, clock_gate,
                output ready);
endinterface

// ----- sv/cspt_divider.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on cspt_pkg
module cspt_divider (
  input  logic               clk,
  input  logic               rst,
  input  cspt_pkg::div_req_t req,
  output cspt_pkg::div_rsp_t rsp
);
  import cspt_pkg::*;

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem, num[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = num;
  assign rsp.remainder = rem;
endmodule

// ----- sv/clock_step_position_tracker_top.sv -----
// clock step position tracker, top level
// depends on cspt_pkg, cspt_evt_if, cspt_pos_if, cspt_divider and the defines header
`include "clock_step_position_tracker_top_defines.svh"

// Each item is an external clock level change or a sequencer reset, and each item gives
// exactly one result: the step event flag, the step index, the measure number and the
// clock gate report. Items are handled one at a time by a small sequencer around a single
// shared bit-serial divider. A reset item goes straight to the finish state, and so does
// an inactive edge, through a load state first when the divider changes and the clock
// count reloads from its shadow. Every active edge walks the five shadow divided positions:
// a lane that does not roll is skipped, one that rolls below the measure length is
// written back, and one that needs to wrap takes a division by the clocks per measure. An
// active divided edge first advances the clock (one division for the position within the
// measure, one for the wrap to the pattern length). A result still waiting at the output
// holds off the next item. Configuration is taken at any edge with cfg_we high; it should
// only be written while no item is in flight.
module clock_step_position_tracker_top #(
  parameter int MAX_PATTERN_STEPS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cspt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cspt_pkg::CFG_DATA_W-1:0] cfg_data,
  cspt_evt_if.sink                      evt,
  cspt_pos_if.source                    pos
);
  import cspt_pkg::*;

  // longest usable pattern, bounded by the register width
  localparam int LEN_MAX = (MAX_PATTERN_STEPS < (1 << PLEN_W) - 1) ?
                           MAX_PATTERN_STEPS : (1 << PLEN_W) - 1;
  localparam int LEN_W = $clog2(LEN_MAX + 1);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(NUM_LANES - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_LOAD = 12'b0000_0000_0010,
    S_WRAP = 12'b0000_0000_0100,
    S_MUL  = 12'b0000_0000_1000,
    S_CHK  = 12'b0000_0001_0000,
    S_QDIV = 12'b0000_0010_0000,
    S_MDIV = 12'b0000_0100_0000,
    S_FIRE = 12'b0000_1000_0000,
    S_LRD  = 12'b0001_0000_0000,
    S_LUPD = 12'b0010_0000_0000,
    S_LDIV = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [MODE_W-1:0] subdiv_mode;
  logic [TPB_W-1:0]  tpb;
  logic [PLEN_W-1:0] plen;
  logic              polarity;

  // position state
  logic [CIM_W-1:0]  cim;          // clocks in measure
  logic [MEAS_W-1:0] measure;
  logic [LEN_W-1:0]  cur_step;
  logic              step_valid;
  logic [CIM_W-1:0]  cpm;          // clocks per measure, updated on advance
  logic              pending;
  logic              force_step;
  logic [PH_W-1:0]   aphase;
  logic [PH_W-1:0]   iphase;
  logic [PH_W-1:0]   last_div;
  logic [PH_W-1:0]   phase [NUM_LANES];

  // shadow divided positions, one per divider, with valid bits for the cleared state
  logic [CIM_W-1:0]     pos_mem [NUM_LANES];
  logic [NUM_LANES-1:0] pos_ok;
  logic [CIM_W-1:0]     rd_data;
  logic                 rd_ok;
  logic [LANE_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [CIM_W-1:0]     wr_data;

  // per item working registers
  logic                 fired_q;
  logic [GATE_W-1:0]    gate_q;
  logic                 adv_q;
  logic                 active_q;
  logic                 wrapped;
  logic [DIV_NUM_W-1:0] prod;
  logic [LANE_W-1:0]    lane;
  logic [NUM_LANES-1:0] lane_wrap;

  // result register
  logic              out_valid;
  logic              out_fired;
  logic [STEP_W-1:0] out_step;
  logic [MEAS_W-1:0] out_measure;
  logic [GATE_W-1:0] out_gate;

  // effective configuration
  logic [TPB_W-1:0]   tpb_eff;
  logic [TPB_W+1:0]   tpb4;
  logic [CIM_W-1:0]   cpm_c;
  logic [LEN_W-1:0]   len_eff;

  // edge decode
  logic                 accept;
  logic [PH_W-1:0]      div_sel;
  logic                 is_active;
  logic                 a_hit;
  logic [PH_W-1:0]      a_nxt;
  logic                 i_hit;
  logic [PH_W-1:0]      i_nxt;
  logic [PH_W-1:0]      ph_inc [NUM_LANES];
  logic [NUM_LANES-1:0] lane_hit;

  // arithmetic operands
  logic [DIV_NUM_W-1:0] mul_prod;
  logic [DIV_NUM_W-2:0] cim_x_tpb;
  logic [CIM_W:0]       lane_p1;
  logic                 lane_small;
  logic [LEN_W-1:0]     next_step;
  logic                 fire;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cspt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      subdiv_mode <= MODE_96;
      tpb         <= TPB_RESET;
      plen        <= PLEN_RESET;
      polarity    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUBDIV:   subdiv_mode <= cfg_data[MODE_W-1:0];
        CFG_TPB:      tpb         <= cfg_data[TPB_W-1:0];
        CFG_PLEN:     plen        <= cfg_data[PLEN_W-1:0];
        CFG_POLARITY: polarity    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ticks per beat clamped to 1..8
  always_comb begin
    if (tpb == '0)         tpb_eff = TPB_W'(1);
    else if (tpb > TPB_MAX) tpb_eff = TPB_MAX;
    else                   tpb_eff = tpb;
  end

  assign tpb4 = {tpb_eff, 2'b00};

  always_comb begin
    case (subdiv_mode)
      MODE_X4: cpm_c = {1'b0, tpb_eff, 2'b00};
      MODE_X8: cpm_c = {tpb_eff, 3'b000};
      MODE_64: cpm_c = CPM_64;
      default: cpm_c = CPM_96;
    endcase
  end

  // pattern length clamped to 1..max steps
  always_comb begin
    if (plen == '0)                                   len_eff = LEN_W'(1);
    else if ({{(32-PLEN_W){1'b0}}, plen} > MAX_PATTERN_STEPS) len_eff = LEN_W'(LEN_MAX);
    else                                              len_eff = LEN_W'(plen);
  end

  // ---------------------------------------------------------------- edge decode
  assign evt.ready = (state == S_IDLE) && (!out_valid || pos.ready);
  assign accept    = evt.valid && evt.ready;
  assign div_sel   = pick_divider(evt.tempo_knob);
  assign is_active = evt.clock_level == polarity;
  assign a_hit     = small_mod(aphase, div_sel) == '0;
  assign a_nxt     = small_mod(aphase + PH_W'(1), div_sel);
  assign i_hit     = small_mod(iphase, div_sel) == '0;
  assign i_nxt     = small_mod(iphase + PH_W'(1), div_sel);

  // lane i runs the shadow position for divider i+1
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      ph_inc[i]   = phase[i] + PH_W'(1);
      lane_hit[i] = ph_inc[i] >= PH_W'(i + 1);
    end
  end

  // ---------------------------------------------------------------- arithmetic operands
  assign mul_prod   = {{(DIV_NUM_W-MEAS_W){1'b0}}, measure} *
                      {{(DIV_NUM_W-TPB_W-2){1'b0}}, tpb4};
  assign cim_x_tpb  = {{(DIV_NUM_W-1-CIM_W){1'b0}}, cim} *
                      {{(DIV_NUM_W-1-TPB_W-2){1'b0}}, tpb4};
  assign lane_p1    = {1'b0, rd_ok ? rd_data : {CIM_W{1'b0}}} + (CIM_W+1)'(1);
  assign lane_small = lane_p1 < {1'b0, cpm};
  assign next_step  = pending ? '0 : LEN_W'(div_rsp.remainder);
  assign fire       = !step_valid || (next_step != cur_step) || force_step || pending;

  // divider requests: quotient within measure, pattern wrap, shadow position wrap
  always_comb begin
    div_req = '0;
    case (state)
      S_CHK: begin
        div_req.start    = 1'b1;
        div_req.dividend = {cim_x_tpb, 1'b0};
        div_req.divisor  = DIV_DEN_W'(cpm);
        div_req.iters    = ITER_QUOT;
      end
      S_QDIV: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = prod + div_rsp.quotient;
        div_req.divisor  = DIV_DEN_W'(len_eff);
        div_req.iters    = ITER_MOD;
      end
      S_LUPD: begin
        div_req.start    = !lane_small;
        div_req.dividend = {lane_p1, 5'b00000};
        div_req.divisor  = DIV_DEN_W'(cpm);
        div_req.iters    = ITER_LANE;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- shadow position memory
  assign rd_addr = (state == S_IDLE) ? LANE_W'(div_sel - PH_W'(1)) : lane;
  assign wr_en   = ((state == S_LUPD) && lane_small) || ((state == S_LDIV) && div_rsp.done);
  assign wr_data = (state == S_LDIV) ? CIM_W'(div_rsp.remainder) : CIM_W'(lane_p1);

  always_ff @(posedge clk) begin
    rd_data <= pos_mem[rd_addr];
    if (wr_en) pos_mem[lane] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      rd_ok <= pos_ok[rd_addr];
      if (accept && (evt.kind == KIND_RESET)) pos_ok <= '0;
      else if (wr_en)                         pos_ok[lane] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cim        <= '0;
      measure    <= '0;
      cur_step   <= '0;
      step_valid <= 1'b0;
      cpm        <= CPM_96;
      pending    <= 1'b1;
      force_step <= 1'b0;
      aphase     <= '0;
      iphase     <= '0;
      last_div   <= DIV_NONE;
      lane       <= '0;
      for (int i = 0; i < NUM_LANES; i++) phase[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            fired_q <= 1'b0;
            gate_q  <= GATE_NONE;
            lane    <= '0;
            if (evt.kind == KIND_RESET) begin
              // sequencer reset: position cleared, step kept, next advance forces a step
              pending    <= 1'b1;
              force_step <= 1'b1;
              measure    <= '0;
              cim        <= '0;
              aphase     <= '0;
              iphase     <= '0;
              for (int i = 0; i < NUM_LANES; i++) phase[i] <= '0;
              state <= S_FIN;
            end else begin
              active_q <= is_active;
              adv_q    <= is_active && a_hit;
              if (is_active) begin
                if (a_hit) gate_q <= GATE_SET;
                aphase <= a_nxt;
                for (int i = 0; i < NUM_LANES; i++) begin
                  phase[i]     <= lane_hit[i] ? '0 : ph_inc[i];
                  lane_wrap[i] <= lane_hit[i];
                end
              end else begin
                if (i_hit) gate_q <= GATE_CLEAR;
                iphase <= i_nxt;
              end
              // divider change: clock count reloads from that divider's shadow
              if (last_div != div_sel) begin
                last_div <= div_sel;
                state    <= S_LOAD;
              end else if (is_active && a_hit) begin
                state <= S_WRAP;
              end else if (is_active) begin
                state <= S_LRD;
              end else begin
                state <= S_FIN;
              end
            end
          end
        end

        S_LOAD: begin
          cim <= rd_ok ? rd_data : '0;
          if (adv_q)         state <= S_WRAP;
          else if (active_q) state <= S_LRD;
          else               state <= S_FIN;
        end

        // measure rollover
        S_WRAP: begin
          cpm <= cpm_c;
          if (cim >= cpm_c) begin
            cim     <= '0;
            measure <= measure + MEAS_W'(1);
            wrapped <= 1'b1;
          end else begin
            wrapped <= 1'b0;
          end
          state <= S_MUL;
        end

        S_MUL: begin
          prod  <= mul_prod;
          state <= S_CHK;
        end

        // measure past the pattern end starts over
        S_CHK: begin
          if (wrapped && (prod >= DIV_NUM_W'(len_eff))) begin
            measure <= '0;
            prod    <= '0;
          end
          state <= S_QDIV;
        end

        S_QDIV: begin
          if (div_rsp.done) state <= S_MDIV;
        end

        S_MDIV: begin
          if (div_rsp.done) state <= S_FIRE;
        end

        S_FIRE: begin
          if (fire) begin
            cur_step   <= next_step;
            step_valid <= 1'b1;
            fired_q    <= 1'b1;
          end
          pending    <= 1'b0;
          force_step <= 1'b0;
          cim        <= cim + CIM_W'(1);
          state      <= S_LRD;
        end

        // shadow lanes, only those whose divided clock rolled over
        S_LRD: begin
          if (lane_wrap[lane]) begin
            state <= S_LUPD;
          end else if (lane == LANE_LAST) begin
            state <= S_FIN;
          end else begin
            lane <= lane + LANE_W'(1);
          end
        end

        S_LUPD: begin
          if (!lane_small) begin
            state <= S_LDIV;
          end else if (lane == LANE_LAST) begin
            state <= S_FIN;
          end else begin
            lane  <= lane + LANE_W'(1);
            state <= S_LRD;
          end
        end

        S_LDIV: begin
          if (div_rsp.done) begin
            if (lane == LANE_LAST) begin
              state <= S_FIN;
            end else begin
              lane  <= lane + LANE_W'(1);
              state <= S_LRD;
            end
          end
        end

        S_FIN: begin
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN) begin
      out_valid <= 1'b1;
    end else if (pos.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      out_fired   <= fired_q;
      out_step    <= step_valid ? STEP_W'(cur_step) : '0;
      out_measure <= measure;
      out_gate    <= gate_q;
    end
  end

  assign pos.valid         = out_valid;
  assign pos.step_fired    = out_fired;
  assign pos.step_index    = out_step;
  assign pos.measure_count = out_measure;
  assign pos.clock_gate    = out_gate;

  // ---------------------------------------------------------------- assertions
  `CSPT_ASSERT(a_reset_item_clears,
    (accept && (evt.kind == KIND_RESET)) |=> ((state == S_FIN) && pending && (measure == '0)),
    "reset item did not clear the position")
  `CSPT_ASSERT(a_fin_slot_free, (state == S_FIN) |-> !out_valid,
    "result register still busy at finish")
  `CSPT_ASSERT(a_step_in_range, (state == S_FIRE) |=> (step_valid && (cur_step < len_eff)),
    "step index outside the pattern")
  `CSPT_ASSERT(a_divisor_nonzero, ((state == S_CHK) || (state == S_LUPD)) |-> (cpm != '0),
    "division by zero clocks per measure")

endmodule
